>>> design/tkss_pkg.sv
// Shared types and constants for the top-k score selection block.
package tkss_pkg;

  localparam int unsigned MAX_KEPT_DEF   = 16;
  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned SCORE_W        = 32;
  localparam int unsigned ENTRY_INDEX_W  = 16;
  localparam int unsigned TOP_COUNT_W    = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming item
    logic insert;  // update the sorted chain with the captured item
    logic emit;    // present the head entry and shift the chain up
  } tkss_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_item;    // captured item closes the set
    logic remain_zero;  // no entries left to emit
    logic remain_one;   // exactly one entry left to emit
  } tkss_sts_t;

endpackage

>>> design/tkss_ctrl.sv
// Controller state machine for the top-k score selection block.
module tkss_ctrl
  import tkss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tkss_sts_t sts_i,
  output tkss_cmd_t cmd_o,
  output logic      busy_o,
  output logic      last_emit_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Sequence: take item, insert it, then drain the chain when the set ends
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    last_emit_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = sts_i.last_item ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.remain_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.emit  = 1'b1;
          last_emit_o = sts_i.remain_one;
          if (sts_i.remain_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> design/tkss_datapath.sv
// Datapath: sorted chain of kept entries, set counters and the limit register.
module tkss_datapath
  import tkss_pkg::*;
#(
  parameter int unsigned MAX_KEPT   = MAX_KEPT_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tkss_cmd_t                cmd_i,
  output tkss_sts_t                sts_o,
  input  logic [SCORE_W-1:0]       score_i,
  input  logic                     last_item_i,
  input  logic                     cfg_we_i,
  input  logic [TOP_COUNT_W-1:0]   cfg_top_count_i,
  output logic [SCORE_W-1:0]       head_score_o,
  output logic [INDEX_BITS-1:0]    head_index_o
);

  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);

  // Entry a ranks ahead of entry b: higher score, then lower index
  function automatic logic ranks_before(input logic [SCORE_W-1:0]    sa,
                                        input logic [INDEX_BITS-1:0] ia,
                                        input logic [SCORE_W-1:0]    sb,
                                        input logic [INDEX_BITS-1:0] ib);
    logic r;
    if (sa != sb) r = (sa > sb);
    else          r = (ia < ib);
    return r;
  endfunction

  logic [SCORE_W-1:0]     cell_score_q [MAX_KEPT];
  logic [SCORE_W-1:0]     cell_score_d [MAX_KEPT];
  logic [INDEX_BITS-1:0]  cell_index_q [MAX_KEPT];
  logic [INDEX_BITS-1:0]  cell_index_d [MAX_KEPT];
  logic [SCORE_W-1:0]     score_q;
  logic [INDEX_BITS-1:0]  index_q;
  logic                   last_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       remain_q, remain_d;
  logic [INDEX_BITS-1:0]  position_q, position_d;
  logic [TOP_COUNT_W-1:0] top_count_q;

  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    count_after;
  logic [MAX_KEPT-1:0] ahead, prev_ahead, is_tail, greater;
  logic                full, do_ins, do_rep;

  // Clamp the requested count to 1..MAX_KEPT
  always_comb begin
    if (top_count_q == '0) begin
      limit = CNT_W'(1);
    end else if (32'(top_count_q) > 32'(MAX_KEPT)) begin
      limit = CNT_W'(MAX_KEPT);
    end else begin
      limit = CNT_W'(top_count_q);
    end
  end

  // Compare the new item against every cell at once
  always_comb begin
    for (int k = 0; k < MAX_KEPT; k++) begin
      ahead[k]   = (CNT_W'(k) < count_q) &&
                   ranks_before(cell_score_q[k], cell_index_q[k], score_q, index_q);
      is_tail[k] = (CNT_W'(k + 1) == count_q);
      greater[k] = (score_q > cell_score_q[k]);
    end
    prev_ahead[0] = 1'b0;
    for (int k = 1; k < MAX_KEPT; k++) begin
      prev_ahead[k] = ahead[k-1];
    end
  end

  assign full   = (count_q >= limit);
  assign do_ins = !full && (score_q != '0) && (32'(count_q) < 32'(MAX_KEPT));
  assign do_rep = full && (count_q != '0) && |(greater & is_tail);
  assign count_after = do_ins ? count_q + CNT_W'(1) : count_q;

  // Insert into the sorted chain, or shift it up while emitting
  always_comb begin
    for (int k = 0; k < MAX_KEPT; k++) begin
      cell_score_d[k] = cell_score_q[k];
      cell_index_d[k] = cell_index_q[k];
    end
    if (cmd_i.insert && (do_ins || do_rep)) begin
      for (int k = 0; k < MAX_KEPT; k++) begin
        if (!ahead[k]) begin
          if ((k == 0) || prev_ahead[k]) begin
            cell_score_d[k] = score_q;
            cell_index_d[k] = index_q;
          end else begin
            cell_score_d[k] = cell_score_q[(k == 0) ? 0 : k - 1];
            cell_index_d[k] = cell_index_q[(k == 0) ? 0 : k - 1];
          end
        end
      end
    end else if (cmd_i.emit) begin
      for (int k = 0; k + 1 < MAX_KEPT; k++) begin
        cell_score_d[k] = cell_score_q[k+1];
        cell_index_d[k] = cell_index_q[k+1];
      end
    end
  end

  // Advance set counters; close the set on the last item
  always_comb begin
    count_d    = count_q;
    remain_d   = remain_q;
    position_d = position_q;
    if (cmd_i.insert) begin
      if (last_q) begin
        count_d    = '0;
        position_d = '0;
        remain_d   = (count_after < limit) ? count_after : limit;
      end else begin
        count_d    = count_after;
        position_d = position_q + INDEX_BITS'(1);
      end
    end else if (cmd_i.emit) begin
      remain_d = remain_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      remain_q    <= '0;
      position_q  <= '0;
      top_count_q <= TOP_COUNT_W'(1);
      last_q      <= 1'b0;
    end else begin
      count_q    <= count_d;
      remain_q   <= remain_d;
      position_q <= position_d;
      if (cfg_we_i) begin
        top_count_q <= cfg_top_count_i;
      end
      if (cmd_i.load) begin
        last_q <= last_item_i;
      end
    end
  end

  // Hold item and cell payloads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      score_q <= score_i;
      index_q <= position_q;
    end
    for (int k = 0; k < MAX_KEPT; k++) begin
      cell_score_q[k] <= cell_score_d[k];
      cell_index_q[k] <= cell_index_d[k];
    end
  end

  assign sts_o.last_item   = last_q;
  assign sts_o.remain_zero = (remain_q == '0);
  assign sts_o.remain_one  = (remain_q == CNT_W'(1));
  assign head_score_o      = cell_score_q[0];
  assign head_index_o      = cell_index_q[0];

endmodule

>>> design/top_k_score_select_core.sv
// Top level of the top-k score selection block.
//
// Input: one score per item, taken at a rising edge where start is high and
// busy is low. The item's position in the current set is its index.
// last_item_i marks the final item of a set.
// Each item is accepted in idle and then passes through the insert state, in which
// the new score is compared against all kept entries in parallel and the
// sorted cell chain shifts to make room.
// After an item marked last, the block emits min(kept, limit) results, limit
// being top_count clamped to 1..MAX_KEPT, best first, one per cycle from the
// head of the chain; last_result_o marks the final one. With nothing kept, the
// block enters the emit state, gives no result and returns to idle.
// result_strobe_o marks each result for exactly one cycle; the receiver
// cannot stall, so results are never held.
// Configuration: cfg_valid writes cfg_top_count_i; cfg_ready is always high.
// Write it only while the block is idle.
// Reset clears the kept count, the stream position and sets top_count to 1.
module top_k_score_select_core
  import tkss_pkg::*;
#(
  parameter int unsigned MAX_KEPT   = MAX_KEPT_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [SCORE_W-1:0]       score_i,
  input  logic                     last_item_i,
  output logic                     result_strobe_o,
  output logic [ENTRY_INDEX_W-1:0] entry_index_o,
  output logic [SCORE_W-1:0]       entry_score_o,
  output logic                     last_result_o,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TOP_COUNT_W-1:0]   cfg_top_count_i
);

  tkss_cmd_t             cmd;
  tkss_sts_t             sts;
  logic                  busy_int;
  logic                  last_emit;
  logic [INDEX_BITS-1:0] head_index;

  tkss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_int),
    .last_emit_o (last_emit)
  );

  tkss_datapath #(
    .MAX_KEPT   (MAX_KEPT),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .score_i         (score_i),
    .last_item_i     (last_item_i),
    .cfg_we_i        (cfg_valid & cfg_ready),
    .cfg_top_count_i (cfg_top_count_i),
    .head_score_o    (entry_score_o),
    .head_index_o    (head_index)
  );

  // Drive the result channel from the chain head
  assign busy            = busy_int;
  assign cfg_ready       = 1'b1;
  assign result_strobe_o = cmd.emit;
  assign last_result_o   = last_emit;
  assign entry_index_o   = ENTRY_INDEX_W'(head_index);

endmodule

>>> design/tkss_checker.sv
// Port-level checker for the top-k score selection block, with its bind.
module tkss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_item_i,
  input logic result_strobe_o,
  input logic last_result_o
);

  // Results only appear while an item is in work
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy)
    else $error("result strobe while idle");

  // A final-result flag needs a strobe
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> result_strobe_o)
    else $error("last_result without strobe");

  // An ordinary item passes through the insert state with no result and then frees the block
  a_plain_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_item_i) |=> (busy && !result_strobe_o) ##1 !busy)
    else $error("plain item did not finish in two cycles");

  // The block goes idle right after the final result
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |=> !busy)
    else $error("busy after final result");

  // No result in the cycle after an item is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_strobe_o)
    else $error("result during insert cycle");

endmodule

bind top_k_score_select_core tkss_checker u_tkss_checker (.*);
